// ===== hdl/bmhq_pkg.sv =====
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared sizes, types, codes and address helpers of the binary min-heap
// priority queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    // Store geometry and field widths
    localparam int HEAP_DEPTH  = 1024;
    localparam int KEY_BITS    = 32;
    localparam int TAG_BITS    = 16;
    localparam int ENTRY_BITS  = KEY_BITS + TAG_BITS;
    localparam int CNT_BITS    = $clog2(HEAP_DEPTH + 1);
    localparam int BANK_DEPTH  = (HEAP_DEPTH + 1) / 2;
    localparam int BANK_AW     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    // Stream packing
    localparam int IN_DATA_BITS  = ((ENTRY_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((ENTRY_BITS + CNT_BITS + 7) / 8) * 8;
    localparam int TAG_LSB       = KEY_BITS;
    localparam int OCC_LSB       = ENTRY_BITS;

    typedef logic [KEY_BITS-1:0] t_key;
    typedef logic [TAG_BITS-1:0] t_tag;
    typedef logic [CNT_BITS-1:0] t_pos;
    typedef logic [CNT_BITS:0]   t_cpos;
    typedef logic [BANK_AW-1:0]  t_baddr;

    typedef struct packed {
        t_tag tag;
        t_key key;
    } t_entry;

    localparam t_pos POS_ROOT = t_pos'(1);
    localparam t_pos POS_FULL = t_pos'(HEAP_DEPTH);

    // Request kinds
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_RM_LAST,
        S_RM_ROOT,
        S_RM_TAKE,
        S_DN_RD,
        S_DN_CMP,
        S_DONE
    } t_state;

    // Heap positions 1..N map to index pos-1; even index in bank 0, odd in bank 1,
    // so the two children of any node sit in different banks.
    function automatic logic bank_sel(t_cpos p);
        t_cpos t;
        t = p - t_cpos'(1);
        return t[0];
    endfunction

    function automatic t_baddr bank_addr(t_cpos p);
        t_cpos t;
        t = p - t_cpos'(1);
        return t[BANK_AW:1];
    endfunction

endpackage

// ===== hdl/bmhq_ram.sv =====
// ----------------------------------------------------------------------------
// bmhq_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module bmhq_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/binary_min_heap_queue_top.sv =====
// ----------------------------------------------------------------------------
// binary_min_heap_queue_top
// Priority queue kept as a one-based binary min-heap in two RAM banks.
// ----------------------------------------------------------------------------
// Each request is an insert (key, tag) or a remove of the smallest key; each
// request returns exactly one result with the removed entry (zero otherwise),
// a status and the occupancy afterwards. Requests are handled one at a time.
// An insert climbs towards the root and a remove sinks from the root; an
// entry moves at most 10 levels for an insert and 9 for a remove at 1024
// entries. Refused requests go straight to their result. Each heap level
// costs one registered RAM read and one compare-and-write; the store is split
// into even and odd banks so both children of a node are read in the same
// cycle. A new request is accepted while the previous result still waits in
// the output register. No clearing pass is needed after reset.
module binary_min_heap_queue_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [bmhq_pkg::IN_DATA_BITS-1:0]   i_s_axis_tdata,  // in_key, in_tag
    input  logic                                i_s_axis_tuser,  // kind
    // result stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [bmhq_pkg::OUT_DATA_BITS-1:0]  o_m_axis_tdata,  // out_key, out_tag, occupancy
    output logic [1:0]                          o_m_axis_tuser   // status
);

    import bmhq_pkg::*;

    t_state  r_state,  n_state;
    t_pos    r_count,  n_count;
    t_pos    r_pos,    n_pos;
    t_entry  r_move,   n_move;
    t_key    r_res_key, n_res_key;
    t_tag    r_res_tag, n_res_tag;
    t_status r_res_st, n_res_st;
    logic    r_ovalid, n_ovalid;
    t_key    r_okey,   n_okey;
    t_tag    r_otag,   n_otag;
    t_status r_ost,    n_ost;
    t_pos    r_oocc,   n_oocc;

    logic    in_acc;
    t_cpos   pos_ext, cnt_ext, parent_ext, lchild, rchild, cidx;
    t_entry  rdata0, rdata1, par_data, last_data, child;
    logic    up_swap, use_r, dn_move;

    logic    w_en, we0, we1;
    t_cpos   w_pos;
    t_entry  w_data;
    t_baddr  waddr, raddr0, raddr1;

    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;

    // Position arithmetic
    assign pos_ext    = {1'b0, r_pos};
    assign cnt_ext    = {1'b0, r_count};
    assign parent_ext = pos_ext >> 1;
    assign lchild     = {r_pos, 1'b0};
    assign rchild     = lchild + t_cpos'(1);

    // Compare paths
    assign par_data  = bank_sel(parent_ext) ? rdata1 : rdata0;
    assign last_data = bank_sel(cnt_ext) ? rdata1 : rdata0;
    assign up_swap   = par_data.key > r_move.key;
    assign use_r     = (rchild <= cnt_ext) && (rdata0.key < rdata1.key);
    assign child     = use_r ? rdata0 : rdata1;
    assign cidx      = use_r ? rchild : lchild;
    assign dn_move   = child.key < r_move.key;

    // Memory control
    always_comb begin
        w_en   = 1'b0;
        w_pos  = pos_ext;
        w_data = r_move;
        raddr0 = bank_addr(pos_ext);
        raddr1 = bank_addr(pos_ext);
        case (r_state)
            S_UP_RD: begin
                if (r_pos == POS_ROOT) begin
                    w_en = 1'b1;
                end else begin
                    raddr0 = bank_addr(parent_ext);
                    raddr1 = bank_addr(parent_ext);
                end
            end
            S_UP_CMP: begin
                w_en   = 1'b1;
                w_data = up_swap ? par_data : r_move;
            end
            S_RM_LAST: begin
                raddr0 = bank_addr(cnt_ext);
                raddr1 = bank_addr(cnt_ext);
            end
            S_RM_ROOT: begin
                raddr0 = bank_addr(t_cpos'(1));
                raddr1 = bank_addr(t_cpos'(1));
            end
            S_DN_RD: begin
                if (lchild > cnt_ext) begin
                    w_en = 1'b1;
                end else begin
                    raddr1 = bank_addr(lchild);
                    raddr0 = bank_addr(rchild);
                end
            end
            S_DN_CMP: begin
                w_en   = 1'b1;
                w_data = dn_move ? child : r_move;
            end
            default: begin
                w_en = 1'b0;
            end
        endcase
    end

    assign we0   = w_en && !bank_sel(w_pos);
    assign we1   = w_en && bank_sel(w_pos);
    assign waddr = bank_addr(w_pos);

    // Even-index bank
    bmhq_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (BANK_DEPTH)
    ) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (we0),
        .i_waddr (waddr),
        .i_wdata (w_data),
        .i_raddr (raddr0),
        .o_rdata (rdata0)
    );

    // Odd-index bank
    bmhq_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (BANK_DEPTH)
    ) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (we1),
        .i_waddr (waddr),
        .i_wdata (w_data),
        .i_raddr (raddr1),
        .o_rdata (rdata1)
    );

    // Next state and datapath registers
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pos     = r_pos;
        n_move    = r_move;
        n_res_key = r_res_key;
        n_res_tag = r_res_tag;
        n_res_st  = r_res_st;
        n_ovalid  = r_ovalid;
        n_okey    = r_okey;
        n_otag    = r_otag;
        n_ost     = r_ost;
        n_oocc    = r_oocc;

        // drop a taken result
        if (r_ovalid && i_m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res_key = '0;
                    n_res_tag = '0;
                    n_res_st  = ST_OK;
                    if (i_s_axis_tuser == KIND_REMOVE) begin
                        if (r_count == '0) begin
                            n_res_st = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_RM_LAST;
                        end
                    end else begin
                        if (r_count == POS_FULL) begin
                            n_res_st = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_count  = r_count + t_pos'(1);
                            n_pos    = r_count + t_pos'(1);
                            n_move.key = i_s_axis_tdata[KEY_BITS-1:0];
                            n_move.tag = i_s_axis_tdata[TAG_LSB +: TAG_BITS];
                            n_state  = S_UP_RD;
                        end
                    end
                end
            end
            S_UP_RD: begin
                n_state = (r_pos == POS_ROOT) ? S_DONE : S_UP_CMP;
            end
            S_UP_CMP: begin
                if (up_swap) begin
                    n_pos   = parent_ext[CNT_BITS-1:0];
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RM_LAST: begin
                n_state = S_RM_ROOT;
            end
            S_RM_ROOT: begin
                n_move  = last_data;
                n_state = S_RM_TAKE;
            end
            S_RM_TAKE: begin
                n_res_key = rdata0.key;
                n_res_tag = rdata0.tag;
                n_count   = r_count - t_pos'(1);
                n_pos     = POS_ROOT;
                n_state   = (r_count == POS_ROOT) ? S_DONE : S_DN_RD;
            end
            S_DN_RD: begin
                n_state = (lchild > cnt_ext) ? S_DONE : S_DN_CMP;
            end
            S_DN_CMP: begin
                if (dn_move) begin
                    n_pos   = cidx[CNT_BITS-1:0];
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hand the result over once the output register is free
                if (!r_ovalid || i_m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_okey   = r_res_key;
                    n_otag   = r_res_tag;
                    n_ost    = r_res_st;
                    n_oocc   = r_count;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_move    <= n_move;
        r_res_key <= n_res_key;
        r_res_tag <= n_res_tag;
        r_res_st  <= n_res_st;
        r_okey    <= n_okey;
        r_otag    <= n_otag;
        r_ost     <= n_ost;
        r_oocc    <= n_oocc;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = OUT_DATA_BITS'({r_oocc, r_otag, r_okey});
    assign o_m_axis_tuser  = r_ost;

endmodule

// ===== hdl/bmhq_checker.sv =====
// ----------------------------------------------------------------------------
// bmhq_port_checker
// Port-level checks of the heap queue results, bound to the top level.
// ----------------------------------------------------------------------------
module bmhq_port_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    input  logic                                o_s_axis_tready,
    input  logic [bmhq_pkg::IN_DATA_BITS-1:0]   i_s_axis_tdata,  // in_key, in_tag
    input  logic                                i_s_axis_tuser,  // kind
    input  logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    input  logic [bmhq_pkg::OUT_DATA_BITS-1:0]  o_m_axis_tdata,  // out_key, out_tag, occupancy
    input  logic [1:0]                          o_m_axis_tuser   // status
);

    import bmhq_pkg::*;

    t_pos occ;
    logic key_tag_zero;

    assign occ          = o_m_axis_tdata[OCC_LSB +: CNT_BITS];
    assign key_tag_zero = (o_m_axis_tdata[ENTRY_BITS-1:0] == '0);

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata)
            && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // Occupancy stays within the store
    a_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> occ <= POS_FULL)
        else $error("occupancy beyond store depth");

    // A refused request returns no entry
    a_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == ST_FULL || o_m_axis_tuser == ST_EMPTY)
            |-> key_tag_zero)
        else $error("refused request returned an entry");

    // Empty refusal reports an empty store, full refusal a full one
    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser != ST_EMPTY || occ == '0)
            && (o_m_axis_tuser != ST_FULL || occ == POS_FULL))
        else $error("refusal status disagrees with occupancy");

endmodule

bind binary_min_heap_queue_top bmhq_port_checker u_bmhq_checker (.*);
